[src/sfcr_pkg.sv]
// Shared types, register codes and helpers of the spherical fold block.
`timescale 1ns / 1ps
`default_nettype none
package sfcr_pkg;

    localparam int CFG_DATA_W  = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int FACTOR_W    = 40;
    localparam int DIV_STEPS   = FACTOR_W;
    localparam int QMAG_W      = 39;
    localparam int DE1_W       = 41;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_SCALE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_FACTOR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFFSET = 3'd6;

    localparam logic [1:0] FOLD_NONE   = 2'd0;
    localparam logic [1:0] FOLD_INNER  = 2'd1;
    localparam logic [1:0] FOLD_INVERT = 2'd2;

    localparam logic [FACTOR_W-1:0] FACTOR_ONE = 40'h00_0100_0000;
    localparam logic [DE1_W-1:0]    DE_ONE     = 41'h000_0001_0000;

    typedef struct packed {
        logic [31:0] px_in;
        logic [31:0] py_in;
        logic [31:0] pz_in;
        logic [31:0] de_in;
        logic        cylinder_mode;
    } t_in_item;

    typedef struct packed {
        logic [31:0] px_out;
        logic [31:0] py_out;
        logic [31:0] pz_out;
        logic [31:0] de_out;
        logic [1:0]  fold_kind;
    } t_out_item;

    typedef struct packed {
        logic [31:0]      half_height;
        logic [31:0]      cap_scale;
        logic [31:0]      point_scale;
        logic [30:0]      inner_radius_sq;
        logic [30:0]      outer_radius_sq;
        logic [30:0]      inner_factor;
        logic [2:0][15:0] offset;
    } t_cfg;

    // item state between radius front end, divider steps and fold back end
    typedef struct packed {
        logic [1:0]              kind;
        logic                    sat;
        logic [30:0]             d;
        logic [30:0]             rem;
        logic [15:0]             num;
        logic [FACTOR_W-1:0]     quo;
        logic [2:0]              q_neg;
        logic [2:0][QMAG_W-1:0]  q_mag;
        logic [DE1_W-1:0]        de1;
    } t_mid;

    function automatic logic [31:0] f_mag32(logic [31:0] v);
        f_mag32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    // Q4.12 offset widened to Q8.24, 33 bits signed
    function automatic logic [32:0] f_off33(logic [15:0] o);
        f_off33 = {{5{o[15]}}, o, 12'b0};
    endfunction

endpackage
`default_nettype wire

[src/sfcr_radius.sv]
// Front end: squared radius, offset and scaled point, fold class, divider setup.
`timescale 1ns / 1ps
`default_nettype none
module sfcr_radius (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  sfcr_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  sfcr_pkg::t_in_item i_item,
    output logic              o_valid,
    output sfcr_pkg::t_mid    o_mid
);

    logic [5:0] r_v;

    // stage 1: magnitudes, excess height, offset point
    logic [31:0]      n1_mx, n1_my, n1_mz;
    logic [33:0]      n1_t;
    logic [2:0][32:0] n1_a;
    logic [2:0][31:0] n1_amag;
    logic [2:0][31:0] w_p;
    logic [31:0]      w_ps_mag;
    logic [31:0]      w_cap_mag;

    logic [31:0]      r1_mx, r1_my, r1_mz;
    logic             r1_cyl, r1_tpos;
    logic [32:0]      r1_tu;
    logic [2:0]       r1_aneg;
    logic [2:0][31:0] r1_amag;
    logic [31:0]      r1_de;

    assign w_p       = {i_item.pz_in, i_item.py_in, i_item.px_in};
    assign w_ps_mag  = sfcr_pkg::f_mag32(i_cfg.point_scale);
    assign w_cap_mag = sfcr_pkg::f_mag32(i_cfg.cap_scale);

    always_comb begin
        n1_mx = sfcr_pkg::f_mag32(i_item.px_in);
        n1_my = sfcr_pkg::f_mag32(i_item.py_in);
        n1_mz = sfcr_pkg::f_mag32(i_item.pz_in);
        n1_t  = {2'b00, n1_mz} - {{2{i_cfg.half_height[31]}}, i_cfg.half_height};
        for (int k = 0; k < 3; k++) begin
            n1_a[k]    = {w_p[k][31], w_p[k]} + sfcr_pkg::f_off33(i_cfg.offset[k]);
            n1_amag[k] = n1_a[k][32] ? 32'(~n1_a[k] + 33'd1) : n1_a[k][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mx   <= n1_mx;
            r1_my   <= n1_my;
            r1_mz   <= n1_mz;
            r1_cyl  <= i_item.cylinder_mode;
            r1_tpos <= ~n1_t[33] & (n1_t != 34'd0);
            r1_tu   <= n1_t[32:0];
            for (int k = 0; k < 3; k++) begin
                r1_aneg[k] <= n1_a[k][32];
            end
            r1_amag <= n1_amag;
            r1_de   <= i_item.de_in;
        end
    end

    // stage 2: squares and scale products
    logic [63:0]      n2_tu2;
    logic [63:0]      n2_dep;
    logic [2:0][63:0] n2_qp;

    logic [63:0]      r2_x2, r2_y2, r2_z2;
    logic             r2_cyl, r2_tpos;
    logic [40:0]      r2_sq24;
    logic [2:0]       r2_qneg;
    logic [2:0][sfcr_pkg::QMAG_W-1:0] r2_qmag;
    logic [39:0]      r2_dep;

    always_comb begin
        n2_tu2 = 64'(r1_tu[31:0]) * 64'(r1_tu[31:0]);
        n2_dep = 64'(r1_de) * 64'(w_ps_mag);
        for (int k = 0; k < 3; k++) begin
            n2_qp[k] = 64'(r1_amag[k]) * 64'(w_ps_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_x2   <= 64'(r1_mx) * 64'(r1_mx);
            r2_y2   <= 64'(r1_my) * 64'(r1_my);
            r2_z2   <= 64'(r1_mz) * 64'(r1_mz);
            r2_cyl  <= r1_cyl;
            r2_tpos <= r1_tpos;
            // excess of exactly 2^32 squares to 2^40
            r2_sq24 <= r1_tu[32] ? {1'b1, 40'b0} : {1'b0, n2_tu2[63:24]};
            r2_qneg <= r1_aneg ^ {3{i_cfg.point_scale[31]}};
            for (int k = 0; k < 3; k++) begin
                r2_qmag[k] <= n2_qp[k][62:24];
            end
            r2_dep  <= n2_dep[63:24];
        end
    end

    // stage 3: radius sum, cap weight partial products
    logic [63:0] n3_base;
    logic [39:0] r3_base24;
    logic [55:0] r3_cap_lo;
    logic [48:0] r3_cap_hi;
    logic        r3_use_cap;
    logic [2:0]  r3_qneg;
    logic [2:0][sfcr_pkg::QMAG_W-1:0] r3_qmag;
    logic [sfcr_pkg::DE1_W-1:0] r3_de1;

    assign n3_base = r2_x2 + r2_y2 + (r2_cyl ? 64'd0 : r2_z2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_base24  <= n3_base[63:24];
            r3_cap_lo  <= 56'(r2_sq24[23:0]) * 56'(w_cap_mag);
            r3_cap_hi  <= 49'(r2_sq24[40:24]) * 49'(w_cap_mag);
            r3_use_cap <= r2_cyl & r2_tpos;
            r3_qneg    <= r2_qneg;
            r3_qmag    <= r2_qmag;
            r3_de1     <= {1'b0, r2_dep} + sfcr_pkg::DE_ONE;
        end
    end

    // stage 4: cap term magnitude
    logic [39:0] r4_base24;
    logic [48:0] r4_capv;
    logic        r4_use_cap;
    logic [2:0]  r4_qneg;
    logic [2:0][sfcr_pkg::QMAG_W-1:0] r4_qmag;
    logic [sfcr_pkg::DE1_W-1:0] r4_de1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_base24  <= r3_base24;
            r4_capv    <= r3_cap_hi + 49'(r3_cap_lo[55:24]);
            r4_use_cap <= r3_use_cap;
            r4_qneg    <= r3_qneg;
            r4_qmag    <= r3_qmag;
            r4_de1     <= r3_de1;
        end
    end

    // stage 5: signed squared radius
    logic [49:0] n5_cap;
    logic [49:0] r5_rr;
    logic [2:0]  r5_qneg;
    logic [2:0][sfcr_pkg::QMAG_W-1:0] r5_qmag;
    logic [sfcr_pkg::DE1_W-1:0] r5_de1;

    always_comb begin
        n5_cap = i_cfg.cap_scale[31] ? (~{1'b0, r4_capv} + 50'd1) : {1'b0, r4_capv};
        if (!r4_use_cap) begin
            n5_cap = 50'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_rr   <= {10'b0, r4_base24} + n5_cap;
            r5_qneg <= r4_qneg;
            r5_qmag <= r4_qmag;
            r5_de1  <= r4_de1;
        end
    end

    // stage 6: fold class and divider seed
    logic [1:0] n6_kind;

    always_comb begin
        if ($signed(r5_rr) < $signed({19'b0, i_cfg.inner_radius_sq})) begin
            n6_kind = sfcr_pkg::FOLD_INNER;
        end else if ($signed(r5_rr) < $signed({19'b0, i_cfg.outer_radius_sq})) begin
            n6_kind = sfcr_pkg::FOLD_INVERT;
        end else begin
            n6_kind = sfcr_pkg::FOLD_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_mid.kind  <= n6_kind;
            // quotient of 2^40 or more, zero radius included
            o_mid.sat   <= {16'b0, i_cfg.outer_radius_sq} >= {r5_rr[30:0], 16'b0};
            o_mid.d     <= r5_rr[30:0];
            o_mid.rem   <= {16'b0, i_cfg.outer_radius_sq[30:16]};
            o_mid.num   <= i_cfg.outer_radius_sq[15:0];
            o_mid.quo   <= '0;
            o_mid.q_neg <= r5_qneg;
            o_mid.q_mag <= r5_qmag;
            o_mid.de1   <= r5_de1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    assign o_valid = r_v[5];

endmodule
`default_nettype wire

[src/sfcr_div_step.sv]
// One restoring division step of the inversion factor, one quotient bit.
`timescale 1ns / 1ps
`default_nettype none
module sfcr_div_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  sfcr_pkg::t_mid i_mid,
    output logic           o_valid,
    output sfcr_pkg::t_mid o_mid
);

    logic [31:0]    w_rem2;
    logic [31:0]    w_diff;
    logic           w_ge;
    sfcr_pkg::t_mid n_mid;

    assign w_rem2 = {i_mid.rem, i_mid.num[15]};
    assign w_diff = w_rem2 - {1'b0, i_mid.d};
    assign w_ge   = w_rem2 >= {1'b0, i_mid.d};

    always_comb begin
        n_mid     = i_mid;
        n_mid.rem = w_ge ? w_diff[30:0] : w_rem2[30:0];
        n_mid.num = {i_mid.num[14:0], 1'b0};
        n_mid.quo = {i_mid.quo[sfcr_pkg::FACTOR_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_mid <= n_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

endmodule
`default_nettype wire

[src/sfcr_fold_mul.sv]
// Back end: factor select, split factor multiply, offset removal, saturation.
`timescale 1ns / 1ps
`default_nettype none
module sfcr_fold_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  sfcr_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    input  sfcr_pkg::t_mid      i_mid,
    output logic                o_valid,
    output sfcr_pkg::t_out_item o_item
);

    logic [4:0] r_v;

    // F1: factor, partial products of 21/20 by 20/20 bit halves
    logic [sfcr_pkg::FACTOR_W-1:0] n1_f;
    logic [3:0][40:0]              n1_m;

    logic [3:0][40:0] r1_hh, r1_hl;
    logic [3:0][39:0] r1_lh, r1_ll;
    logic [2:0]       r1_neg;
    logic [1:0]       r1_kind;

    always_comb begin
        case (i_mid.kind)
            sfcr_pkg::FOLD_INNER:  n1_f = {9'b0, i_cfg.inner_factor};
            sfcr_pkg::FOLD_INVERT: n1_f = i_mid.sat ? '1 : i_mid.quo;
            default:               n1_f = sfcr_pkg::FACTOR_ONE;
        endcase
        for (int k = 0; k < 3; k++) begin
            n1_m[k] = {2'b00, i_mid.q_mag[k]};
        end
        n1_m[3] = i_mid.de1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r1_hh[k] <= 41'(n1_m[k][40:20]) * 41'(n1_f[39:20]);
                r1_hl[k] <= 41'(n1_m[k][40:20]) * 41'(n1_f[19:0]);
                r1_lh[k] <= 40'(n1_m[k][19:0]) * 40'(n1_f[39:20]);
                r1_ll[k] <= 40'(n1_m[k][19:0]) * 40'(n1_f[19:0]);
            end
            r1_neg  <= i_mid.q_neg;
            r1_kind <= i_mid.kind;
        end
    end

    // F2: cross terms
    logic [3:0][40:0] r2_hh;
    logic [3:0][41:0] r2_mid;
    logic [3:0][39:0] r2_ll;
    logic [2:0]       r2_neg;
    logic [1:0]       r2_kind;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r2_mid[k] <= {1'b0, r1_hl[k]} + {2'b00, r1_lh[k]};
            end
            r2_hh   <= r1_hh;
            r2_ll   <= r1_ll;
            r2_neg  <= r1_neg;
            r2_kind <= r1_kind;
        end
    end

    // F3: full product, 24 fraction bits dropped
    logic [3:0][80:0] n3_prod;
    logic [3:0][56:0] r3_r;
    logic [2:0]       r3_neg;
    logic [1:0]       r3_kind;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n3_prod[k] = {r2_hh[k][40:0], 40'b0} + {19'b0, r2_mid[k], 20'b0}
                       + {41'b0, r2_ll[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r3_r[k] <= n3_prod[k][80:24];
            end
            r3_neg  <= r2_neg;
            r3_kind <= r2_kind;
        end
    end

    // F4: sign, offset removal, estimate clamp
    logic [2:0][57:0] n4_s;
    logic [2:0][57:0] n4_off;
    logic [2:0][58:0] r4_val;
    logic [31:0]      r4_de;
    logic [1:0]       r4_kind;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n4_s[k]   = r3_neg[k] ? (~{1'b0, r3_r[k]} + 58'd1) : {1'b0, r3_r[k]};
            n4_off[k] = {{25{i_cfg.offset[k][15]}}, sfcr_pkg::f_off33(i_cfg.offset[k])};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r4_val[k] <= {n4_s[k][57], n4_s[k]} - {n4_off[k][57], n4_off[k]};
            end
            r4_de   <= (|r3_r[3][56:32]) ? 32'hFFFF_FFFF : r3_r[3][31:0];
            r4_kind <= r3_kind;
        end
    end

    // F5: signed 32-bit saturation
    logic [2:0][31:0] n5_sat;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r4_val[k][58:31] == '0 || r4_val[k][58:31] == '1) begin
                n5_sat[k] = r4_val[k][31:0];
            end else if (r4_val[k][58]) begin
                n5_sat[k] = 32'h8000_0000;
            end else begin
                n5_sat[k] = 32'h7FFF_FFFF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_item.px_out    <= n5_sat[0];
            o_item.py_out    <= n5_sat[1];
            o_item.pz_out    <= n5_sat[2];
            o_item.de_out    <= r4_de;
            o_item.fold_kind <= r4_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    assign o_valid = r_v[4];

endmodule
`default_nettype wire

[src/spherical_fold_cylinder_radius.sv]
// Top level of the spherical fold with capped-cylinder radius.
`timescale 1ns / 1ps
`default_nettype none
// Spherical fold pipeline: one point per clock in, one folded point per clock
// out. An accepted input passes through 6 front-end stages (squares, cap
// term, radius, fold class), 40 restoring divider stages that produce the
// 40-bit inversion factor one quotient bit each, and 5 back-end stages
// (factor multiply as four partial products of 20- and 21-bit halves, offset
// removal, saturation), then the output buffer. The divider depth sets the
// latency; the rate is one item per cycle whenever the output side keeps
// taking transfers. A two-entry output buffer decouples the sides: the whole
// pipeline advances while the buffer has room, so o_in_stall rises only once
// both entries hold results. Write configuration only while no item is in
// flight.
module spherical_fold_cylinder_radius (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sfcr_pkg::t_in_item  i_in_item,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sfcr_pkg::t_out_item o_out_item,
    // configuration write port
    input  logic                i_cfg_we,
    input  logic [sfcr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfcr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // ---------------- configuration registers ----------------
    sfcr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_height     <= 32'h0080_0000;
            r_cfg.cap_scale       <= 32'h0100_0000;
            r_cfg.point_scale     <= 32'h0100_0000;
            r_cfg.inner_radius_sq <= 31'h0040_0000;
            r_cfg.outer_radius_sq <= 31'h0100_0000;
            r_cfg.inner_factor    <= 31'h0400_0000;
            r_cfg.offset          <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sfcr_pkg::REG_HALF_HEIGHT:   r_cfg.half_height     <= i_cfg_data[31:0];
                sfcr_pkg::REG_CAP_SCALE:     r_cfg.cap_scale       <= i_cfg_data[31:0];
                sfcr_pkg::REG_POINT_SCALE:   r_cfg.point_scale     <= i_cfg_data[31:0];
                sfcr_pkg::REG_INNER_RADIUS:  r_cfg.inner_radius_sq <= i_cfg_data[30:0];
                sfcr_pkg::REG_OUTER_RADIUS:  r_cfg.outer_radius_sq <= i_cfg_data[30:0];
                sfcr_pkg::REG_INNER_FACTOR:  r_cfg.inner_factor    <= i_cfg_data[30:0];
                sfcr_pkg::REG_CENTER_OFFSET: r_cfg.offset          <= i_cfg_data[47:0];
                default: ; // unmapped index: write ignored
            endcase
        end
    end

    // ---------------- pipeline enable ----------------
    // Every stage moves together; it holds only when the output buffer is full.
    logic [1:0] r_cnt;
    logic       w_en;

    assign w_en       = (r_cnt != 2'd2);
    assign o_in_stall = ~w_en;

    // ---------------- front end ----------------
    logic           w_front_valid;
    sfcr_pkg::t_mid w_front_mid;

    sfcr_radius u_radius (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_valid (w_front_valid),
        .o_mid   (w_front_mid)
    );

    // ---------------- divider chain ----------------
    // Stage k produces quotient bit 39-k of outer_radius_sq * 2^24 / rr.
    logic           w_div_valid [sfcr_pkg::DIV_STEPS+1];
    sfcr_pkg::t_mid w_div_mid   [sfcr_pkg::DIV_STEPS+1];

    assign w_div_valid[0] = w_front_valid;
    assign w_div_mid[0]   = w_front_mid;

    for (genvar g = 0; g < sfcr_pkg::DIV_STEPS; g++) begin : g_div
        sfcr_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_div_valid[g]),
            .i_mid   (w_div_mid[g]),
            .o_valid (w_div_valid[g+1]),
            .o_mid   (w_div_mid[g+1])
        );
    end

    // ---------------- back end ----------------
    logic                w_res_valid;
    sfcr_pkg::t_out_item w_res_item;

    sfcr_fold_mul u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_valid (w_div_valid[sfcr_pkg::DIV_STEPS]),
        .i_mid   (w_div_mid[sfcr_pkg::DIV_STEPS]),
        .o_valid (w_res_valid),
        .o_item  (w_res_item)
    );

    // ---------------- output buffer ----------------
    // Two entries; a valid result leaves the pipeline on every enabled cycle.
    sfcr_pkg::t_out_item r_buf [2];
    logic                r_wr_ptr, r_rd_ptr;
    logic                w_push, w_pop;
    logic [1:0]          n_cnt;

    assign w_push = w_en & w_res_valid;
    assign w_pop  = o_out_valid & ~i_out_stall;
    assign n_cnt  = r_cnt + {1'b0, w_push} - {1'b0, w_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= w_res_item;
        end
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_item  = r_buf[r_rd_ptr];

endmodule
`default_nettype wire
